/* rtl/core/tccw_pkg.sv */
// ----------------------------------------------------------------------------
// tccw_pkg
// Shared constants, codes and types of the text console cell writer.
// ----------------------------------------------------------------------------
package tccw_pkg;

   // screen geometry
   localparam int COLUMNS       = 80;
   localparam int ROWS          = 25;
   localparam int CELL_COUNT    = ROWS * COLUMNS;
   localparam int LAST_CELL     = CELL_COUNT - 1;
   localparam int LAST_ROW_BASE = (ROWS - 1) * COLUMNS;

   localparam int ADDR_W = $clog2(CELL_COUNT);
   localparam int ROW_W  = $clog2(ROWS);
   localparam int COL_W  = $clog2(COLUMNS);
   localparam int CELL_W = 16;
   localparam int ATTR_W = 8;

   // field widths of the stream payloads
   localparam int OP_W       = 3;
   localparam int CHAR_W     = 8;
   localparam int TARGET_W   = 8;
   localparam int INDEX_W    = 11;
   localparam int OUT_ROW_W  = 5;
   localparam int OUT_COL_W  = 7;
   localparam int OUT_LIN_W  = 11;
   localparam int REQ_W      = OP_W + CHAR_W + 2 * TARGET_W + INDEX_W;
   localparam int RSP_W      = OUT_ROW_W + OUT_COL_W + OUT_LIN_W + CELL_W;
   localparam int REQ_TDATA_W = ((REQ_W + 7) / 8) * 8;
   localparam int RSP_TDATA_W = ((RSP_W + 7) / 8) * 8;

   // character and attribute codes
   localparam logic [ATTR_W-1:0] RESET_ATTR   = 8'h07;
   localparam logic [CHAR_W-1:0] BLANK_CODE   = 8'd32;
   localparam logic [CHAR_W-1:0] CH_NEWLINE   = 8'd10;
   localparam logic [CHAR_W-1:0] CH_RETURN    = 8'd13;
   localparam logic [CHAR_W-1:0] CH_BACKSPACE = 8'd8;

   typedef enum logic [OP_W-1:0] {
      OP_PUT    = 3'd0,
      OP_UP     = 3'd1,
      OP_DOWN   = 3'd2,
      OP_LEFT   = 3'd3,
      OP_RIGHT  = 3'd4,
      OP_SETPOS = 3'd5,
      OP_CLEAR  = 3'd6,
      OP_READ   = 3'd7
   } op_type;

   typedef enum logic [6:0] {
      ST_INIT  = 7'b0000001,
      ST_IDLE  = 7'b0000010,
      ST_READ  = 7'b0000100,
      ST_COPY  = 7'b0001000,
      ST_FLUSH = 7'b0010000,
      ST_FILL  = 7'b0100000,
      ST_RESP  = 7'b1000000
   } state_type;

   // first member lands in the highest bits, so op ends up at bit 0
   typedef struct packed {
      logic [INDEX_W-1:0]  cell_index;
      logic [TARGET_W-1:0] target_col;
      logic [TARGET_W-1:0] target_row;
      logic [CHAR_W-1:0]   char_code;
      op_type              op;
   } req_type;

   typedef struct packed {
      logic [CELL_W-1:0]    cell_value;
      logic [OUT_LIN_W-1:0] cursor_linear;
      logic [OUT_COL_W-1:0] cursor_col;
      logic [OUT_ROW_W-1:0] cursor_row;
   } rsp_type;

   typedef struct packed {
      logic              en;
      logic [ADDR_W-1:0] addr;
      logic [CELL_W-1:0] data;
   } ram_wr_type;

endpackage

/* rtl/core/tccw_cell_ram.sv */
// ----------------------------------------------------------------------------
// tccw_cell_ram
// Cell store: one write port, one read port, registered read data.
// ----------------------------------------------------------------------------
module tccw_cell_ram import tccw_pkg::*; (
   input  logic              clock,
   input  ram_wr_type        wr,
   input  logic [ADDR_W-1:0] raddr,
   output logic [CELL_W-1:0] rdata
);

   logic [CELL_W-1:0] mem [CELL_COUNT];

   always_ff @(posedge clock) begin
      if (wr.en) begin
         mem[wr.addr] <= wr.data;
      end
   end

   always_ff @(posedge clock) begin
      rdata <= mem[raddr];
   end

endmodule

/* rtl/core/tccw_ctrl.sv */
// ----------------------------------------------------------------------------
// tccw_ctrl
// Cursor, attribute register and the sequencer that drives the cell store.
// ----------------------------------------------------------------------------
module tccw_ctrl import tccw_pkg::*; (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_ready,
   input  req_type           req,
   input  logic              csr_write,
   input  logic [ATTR_W-1:0] csr_wdata,
   output logic              res_valid,
   input  logic              res_ready,
   output rsp_type           res,
   output ram_wr_type        ram_wr,
   output logic [ADDR_W-1:0] ram_raddr,
   input  logic [CELL_W-1:0] ram_rdata
);

   state_type         state_ff, state_in;
   logic [ROW_W-1:0]  row_ff, row_in;
   logic [COL_W-1:0]  col_ff, col_in;
   logic [ADDR_W-1:0] ptr_ff, ptr_in;
   logic [ATTR_W-1:0] attr_ff, attr_in;
   logic [CELL_W-1:0] value_ff, value_in;
   logic              rd_ok_ff, rd_ok_in;
   logic              pend_ff, pend_in;
   logic [ADDR_W-1:0] pend_addr_ff, pend_addr_in;

   logic [ADDR_W-1:0] here;
   logic [ADDR_W-1:0] back_addr;
   logic              last_row;
   logic              last_col;
   logic              printable;
   logic              scroll;
   logic [ROW_W-1:0]  back_row;
   logic [COL_W-1:0]  back_col;

   assign here      = ADDR_W'(row_ff) * ADDR_W'(COLUMNS) + ADDR_W'(col_ff);
   // stepping back one cell is one linear step, except at the home cell
   assign back_addr = (here == '0) ? '0 : here - ADDR_W'(1);
   assign last_row  = (row_ff == ROW_W'(ROWS - 1));
   assign last_col  = (col_ff == COL_W'(COLUMNS - 1));
   assign printable = !req.char_code[CHAR_W-1] && (req.char_code >= BLANK_CODE);

   always_comb begin
      back_row = row_ff;
      back_col = col_ff;
      if (col_ff != '0) begin
         back_col = col_ff - COL_W'(1);
      end else if (row_ff != '0) begin
         back_row = row_ff - ROW_W'(1);
         back_col = COL_W'(COLUMNS - 1);
      end
   end

   assign attr_in = csr_write ? csr_wdata : attr_ff;

   always_comb begin
      state_in     = state_ff;
      row_in       = row_ff;
      col_in       = col_ff;
      ptr_in       = ptr_ff;
      value_in     = value_ff;
      rd_ok_in     = rd_ok_ff;
      pend_in      = 1'b0;
      pend_addr_in = ptr_ff - ADDR_W'(COLUMNS);
      scroll       = 1'b0;
      ram_raddr    = ptr_ff;
      ram_wr.en    = 1'b0;
      ram_wr.addr  = ptr_ff;
      ram_wr.data  = {attr_ff, BLANK_CODE};

      unique case (state_ff)
         ST_INIT: begin
            ram_wr.en   = 1'b1;
            ram_wr.data = {RESET_ATTR, BLANK_CODE};
            if (ptr_ff == ADDR_W'(LAST_CELL)) begin
               ptr_in   = '0;
               state_in = ST_IDLE;
            end else begin
               ptr_in = ptr_ff + ADDR_W'(1);
            end
         end

         ST_IDLE: begin
            ram_raddr = ADDR_W'(req.cell_index);
            if (req_valid) begin
               value_in = '0;
               rd_ok_in = (32'(req.cell_index) < 32'(CELL_COUNT));
               state_in = ST_RESP;
               unique case (req.op)
                  OP_PUT: begin
                     if (req.char_code == CH_NEWLINE) begin
                        col_in = '0;
                        if (last_row) begin
                           scroll = 1'b1;
                        end else begin
                           row_in = row_ff + ROW_W'(1);
                        end
                     end else if (req.char_code == CH_RETURN) begin
                        col_in = '0;
                     end else if (req.char_code == CH_BACKSPACE) begin
                        ram_wr.en   = 1'b1;
                        ram_wr.addr = back_addr;
                        row_in      = back_row;
                        col_in      = back_col;
                     end else if (printable) begin
                        ram_wr.en   = 1'b1;
                        ram_wr.addr = here;
                        ram_wr.data = {attr_ff, req.char_code};
                        if (last_col) begin
                           col_in = '0;
                           if (last_row) begin
                              scroll = 1'b1;
                           end else begin
                              row_in = row_ff + ROW_W'(1);
                           end
                        end else begin
                           col_in = col_ff + COL_W'(1);
                        end
                     end
                  end
                  OP_UP: begin
                     if (row_ff != '0) begin
                        row_in = row_ff - ROW_W'(1);
                     end
                  end
                  OP_DOWN: begin
                     if (!last_row) begin
                        row_in = row_ff + ROW_W'(1);
                     end
                  end
                  OP_LEFT: begin
                     row_in = back_row;
                     col_in = back_col;
                  end
                  OP_RIGHT: begin
                     if (!last_col) begin
                        col_in = col_ff + COL_W'(1);
                     end else if (!last_row) begin
                        row_in = row_ff + ROW_W'(1);
                        col_in = '0;
                     end
                  end
                  OP_SETPOS: begin
                     row_in = (req.target_row >= TARGET_W'(ROWS)) ?
                              ROW_W'(ROWS - 1) : ROW_W'(req.target_row);
                     col_in = (req.target_col >= TARGET_W'(COLUMNS)) ?
                              COL_W'(COLUMNS - 1) : COL_W'(req.target_col);
                  end
                  OP_CLEAR: begin
                     row_in   = '0;
                     col_in   = '0;
                     ptr_in   = '0;
                     state_in = ST_FILL;
                  end
                  OP_READ: begin
                     state_in = ST_READ;
                  end
               endcase
               // the row stays on the last one; the store moves instead
               if (scroll) begin
                  ptr_in   = ADDR_W'(COLUMNS);
                  state_in = ST_COPY;
               end
            end
         end

         ST_READ: begin
            if (rd_ok_ff) begin
               value_in = ram_rdata;
            end
            state_in = ST_RESP;
         end

         // read one row below, write it back one row up in the next cycle
         ST_COPY: begin
            ram_wr.en   = pend_ff;
            ram_wr.addr = pend_addr_ff;
            ram_wr.data = ram_rdata;
            pend_in     = 1'b1;
            if (ptr_ff == ADDR_W'(LAST_CELL)) begin
               state_in = ST_FLUSH;
            end else begin
               ptr_in = ptr_ff + ADDR_W'(1);
            end
         end

         ST_FLUSH: begin
            ram_wr.en   = pend_ff;
            ram_wr.addr = pend_addr_ff;
            ram_wr.data = ram_rdata;
            ptr_in      = ADDR_W'(LAST_ROW_BASE);
            state_in    = ST_FILL;
         end

         ST_FILL: begin
            ram_wr.en = 1'b1;
            if (ptr_ff == ADDR_W'(LAST_CELL)) begin
               state_in = ST_RESP;
            end else begin
               ptr_in = ptr_ff + ADDR_W'(1);
            end
         end

         ST_RESP: begin
            if (res_ready) begin
               state_in = ST_IDLE;
            end
         end

         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_INIT;
         row_ff   <= '0;
         col_ff   <= '0;
         ptr_ff   <= '0;
         attr_ff  <= RESET_ATTR;
         pend_ff  <= 1'b0;
      end else begin
         state_ff <= state_in;
         row_ff   <= row_in;
         col_ff   <= col_in;
         ptr_ff   <= ptr_in;
         attr_ff  <= attr_in;
         pend_ff  <= pend_in;
      end
   end

   always_ff @(posedge clock) begin
      value_ff     <= value_in;
      rd_ok_ff     <= rd_ok_in;
      pend_addr_ff <= pend_addr_in;
   end

   assign req_ready         = (state_ff == ST_IDLE);
   assign res_valid         = (state_ff == ST_RESP);
   assign res.cursor_row    = OUT_ROW_W'(row_ff);
   assign res.cursor_col    = OUT_COL_W'(col_ff);
   assign res.cursor_linear = OUT_LIN_W'(here);
   assign res.cell_value    = value_ff;

endmodule

/* rtl/core/text_console_cell_writer_top.sv */
// ----------------------------------------------------------------------------
// text_console_cell_writer_top
// Text console: cell store, cursor and output register.
// ----------------------------------------------------------------------------
// Requests arrive on req_* (op, character, target position, cell index) and
// each gives exactly one response on rsp_* with the cursor after the request
// and, for a cell read, the cell contents. csr_* writes the attribute byte
// used for every character written and every cell blanked after the reset pass; it is always ready.
// Per request, with the single cell store port pair:
//   put char, cursor moves, set position: accept, then response;
//   put char writes its cell in the accept cycle;
//   cell read: one registered read of the store, then response;
//   scroll (newline or wrap on the last row): copying one cell a cycle
//   then blanking the bottom row;
//   clear: blanking the whole store one cell a cycle.
// Requests are taken one at a time; req_tready is low while one is at work.
// After reset the store is blanked one cell a cycle with
// attribute 7; no request is taken during that pass, CSR writes are.
// A response sits in an output register, so a stalled receiver does not stop
// the next request from being taken; only its own response then waits.
// ----------------------------------------------------------------------------
module text_console_cell_writer_top import tccw_pkg::*; (
   input  logic                   clock,
   input  logic                   reset,
   // op[2:0], char_code[10:3], target_row[18:11], target_col[26:19],
   // cell_index[37:27], zero[39:38]
   input  logic                   req_tvalid,
   output logic                   req_tready,
   input  logic [REQ_TDATA_W-1:0] req_tdata,
   // cursor_row[4:0], cursor_col[11:5], cursor_linear[22:12],
   // cell_value[38:23], zero[39]
   output logic                   rsp_tvalid,
   input  logic                   rsp_tready,
   output logic [RSP_TDATA_W-1:0] rsp_tdata,
   input  logic                   csr_valid,
   output logic                   csr_ready,
   input  logic [ATTR_W-1:0]      csr_data
);

   req_type           req;
   rsp_type           res;
   logic              res_valid;
   logic              res_ready;
   ram_wr_type        ram_wr;
   logic [ADDR_W-1:0] ram_raddr;
   logic [CELL_W-1:0] ram_rdata;

   logic              out_valid_ff, out_valid_in;
   rsp_type           out_data_ff, out_data_in;

   assign req       = req_type'(req_tdata[REQ_W-1:0]);
   assign csr_ready = 1'b1;

   tccw_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_tvalid),
      .req_ready (req_tready),
      .req       (req),
      .csr_write (csr_valid),
      .csr_wdata (csr_data),
      .res_valid (res_valid),
      .res_ready (res_ready),
      .res       (res),
      .ram_wr    (ram_wr),
      .ram_raddr (ram_raddr),
      .ram_rdata (ram_rdata)
   );

   tccw_cell_ram u_ram (
      .clock (clock),
      .wr    (ram_wr),
      .raddr (ram_raddr),
      .rdata (ram_rdata)
   );

   assign res_ready    = !out_valid_ff || rsp_tready;
   assign out_valid_in = res_valid || (out_valid_ff && !rsp_tready);
   assign out_data_in  = (res_valid && res_ready) ? res : out_data_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else begin
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      out_data_ff <= out_data_in;
   end

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = {{(RSP_TDATA_W - RSP_W){1'b0}}, out_data_ff};

endmodule
